>>> rtl/salcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salcp_pkg
// shared types and constants for the suffix array search engine
// ----------------------------------------------------------------------------
package salcp_pkg;

  localparam int unsigned RefDepthDflt    = 1048576;
  localparam int unsigned MaxQueryLenDflt = 32;
  localparam int unsigned RefLenW         = 21;
  localparam int unsigned QLenW           = 6;
  localparam int unsigned AddrW           = 20;
  localparam int unsigned PosW            = 20;
  localparam int unsigned QueryW          = 64;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 21;

  localparam logic [CfgIdxW-1:0] CfgRefLength   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgQueryLength = 1'b1;

  typedef enum logic [1:0] {
    OpLoadBase = 2'd0,
    OpLoadRank = 2'd1,
    OpQuery    = 2'd2,
    OpNone     = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [AddrW-1:0]  addr;
    logic [1:0]        base;
    logic [PosW-1:0]   ref_pos;
    logic [QueryW-1:0] query;
  } cmd_t;

  typedef enum logic [3:0] {
    StIdle,
    StRank0Rd,
    StRank0Wt,
    StHiRd,
    StHiWt,
    StLoop,
    StMidWt,
    StCmpRd,
    StCmpWt,
    StFinalWt,
    StDone
  } state_e;

endpackage

>>> rtl/salcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salcp_front
// command intake and two-entry queue toward the search engine
// ----------------------------------------------------------------------------
module salcp_front
  import salcp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmd_t cmd_i,
  output logic q_valid_o,
  output cmd_t q_cmd_o,
  input  logic q_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o && (cmd_i.op != OpNone);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = (q_pop_i && q_valid_o) ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> busy_o) else $error("full queue not busy");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> (cnt_q <= 2'd1)) else $error("queue jumped");

endmodule

>>> rtl/salcp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salcp_engine
// reference and rank memories with the binary search sequencer
// ----------------------------------------------------------------------------
module salcp_engine
  import salcp_pkg::*;
#(
  parameter int unsigned REF_DEPTH     = RefDepthDflt,
  parameter int unsigned MAX_QUERY_LEN = MaxQueryLenDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cmd_t               q_cmd_i,
  output logic               q_pop_o,
  input  logic [RefLenW-1:0] ref_length_i,
  input  logic [QLenW-1:0]   query_length_i,
  output logic               done_o,
  output logic               idle_o,
  output logic [PosW-1:0]    found_pos_o,
  output logic               too_short_o
);

  localparam int unsigned DW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned CW = 32;

  logic [1:0]      base_mem [REF_DEPTH];
  logic [PosW-1:0] rank_mem [REF_DEPTH];

  state_e state_q, state_d;

  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [5:0]    lo_lcp_q, lo_lcp_d, hi_lcp_q, hi_lcp_d, i_q, i_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [QueryW-1:0] qry_q, qry_d;
  logic [5:0]    len_q, len_d;
  logic [CW-1:0] n_q, n_d;
  logic          is_hi_q, is_hi_d;
  logic [PosW-1:0] res_q, res_d;
  logic          short_q, short_d;

  logic          rk_en, bs_en;
  logic [CW-1:0] rk_addr, bs_addr;
  logic [PosW-1:0] rk_data_q;
  logic [1:0]    bs_data_q;
  logic          rk_ok_q, bs_ok_q;

  logic [5:0]    qlen_sat;
  logic [1:0]    qb;
  logic [CW-1:0] sum_pi;
  logic [CW-1:0] cmd_addr;

  logic wr_base, wr_rank;
  assign cmd_addr = {12'd0, q_cmd_i.addr};
  assign wr_base = (state_q == StIdle) && q_valid_i && (q_cmd_i.op == OpLoadBase)
                   && (cmd_addr < CW'(REF_DEPTH));
  assign wr_rank = (state_q == StIdle) && q_valid_i && (q_cmd_i.op == OpLoadRank)
                   && (cmd_addr < CW'(REF_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_base) begin
      base_mem[cmd_addr[DW-1:0]] <= q_cmd_i.base;
    end
    if (wr_rank) begin
      rank_mem[cmd_addr[DW-1:0]] <= q_cmd_i.ref_pos;
    end
    if (rk_en) begin
      rk_data_q <= rank_mem[rk_addr[DW-1:0]];
      rk_ok_q   <= rk_addr < CW'(REF_DEPTH);
    end
    if (bs_en) begin
      bs_data_q <= base_mem[bs_addr[DW-1:0]];
      bs_ok_q   <= bs_addr < CW'(REF_DEPTH);
    end
  end

  logic [PosW-1:0] rk_val;
  logic [1:0]      bs_val;
  assign rk_val = rk_ok_q ? rk_data_q : '0;
  assign bs_val = bs_ok_q ? bs_data_q : 2'd0;

  assign qlen_sat = (query_length_i > QLenW'(MAX_QUERY_LEN)) ? 6'(MAX_QUERY_LEN)
                                                             : query_length_i;
  assign qb      = qry_q[{i_q[4:0], 1'b0} +: 2];
  assign sum_pi  = pos_q + {26'd0, i_q};

  assign idle_o      = (state_q == StIdle) && !q_valid_i;
  assign found_pos_o = res_q;
  assign too_short_o = short_q;
  assign done_o      = (state_q == StDone);

  always_comb begin
    state_d  = state_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    lo_lcp_d = lo_lcp_q; hi_lcp_d = hi_lcp_q; i_d = i_q;
    pos_d = pos_q; qry_d = qry_q; len_d = len_q; n_d = n_q;
    is_hi_d = is_hi_q; res_d = res_q; short_d = short_q;
    q_pop_o = 1'b0;
    rk_en = 1'b0; rk_addr = '0;
    bs_en = 1'b0; bs_addr = sum_pi;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.op == OpQuery) begin
            qry_d   = q_cmd_i.query;
            len_d   = qlen_sat;
            n_d     = {11'd0, ref_length_i};
            short_d = 1'b0;
            rk_en   = 1'b1;
            rk_addr = '0;
            state_d = StRank0Rd;
          end
        end
      end
      StRank0Rd: begin
        pos_d = {12'd0, rk_val};
        i_d = '0; is_hi_d = 1'b0;
        if (n_q < {26'd0, len_q} + 32'd2) begin
          res_d = rk_val; short_d = 1'b1; state_d = StDone;
        end else begin
          state_d = StCmpRd;
        end
      end
      StHiRd: begin
        pos_d = {12'd0, rk_val};
        i_d = '0; is_hi_d = 1'b1;
        state_d = StCmpRd;
      end
      StLoop: begin
        if (hi_q <= lo_q + 32'd2) begin
          rk_en = 1'b1; rk_addr = lo_q + 32'd1;
          state_d = StFinalWt;
        end else begin
          mid_d = (lo_q + hi_q) >> 1;
          rk_en = 1'b1; rk_addr = (lo_q + hi_q) >> 1;
          state_d = StMidWt;
        end
      end
      StMidWt: begin
        pos_d = {12'd0, rk_val};
        i_d = (lo_lcp_q < hi_lcp_q) ? lo_lcp_q : hi_lcp_q;
        state_d = StCmpRd;
      end
      StCmpRd: begin
        if (i_q < len_q && sum_pi < n_q) begin
          bs_en = 1'b1;
          state_d = StCmpWt;
        end else if (i_q == len_q) begin
          res_d = pos_q[PosW-1:0]; state_d = StDone;
        end else begin
          // ran off the reference end: go right
          state_d = StRank0Wt;
        end
      end
      StCmpWt: begin
        if (qb == bs_val) begin
          i_d = i_q + 6'd1;
          state_d = StCmpRd;
        end else begin
          state_d = StRank0Wt;
        end
      end
      StRank0Wt: begin
        // mismatch or end: decide phase
        if (lo_q == '1 && is_hi_q == 1'b0 && mid_q == '1) begin
          // first rank-0 probe
          lo_lcp_d = i_q;
          rk_en = 1'b1; rk_addr = n_q - {26'd0, len_q};
          state_d = StHiWt;
        end else if (is_hi_q && hi_q == '1) begin
          hi_lcp_d = i_q;
          lo_d = '0; hi_d = n_q - {26'd0, len_q};
          state_d = StLoop;
        end else begin
          if (sum_pi >= n_q || qb > bs_val) begin
            lo_d = mid_q; lo_lcp_d = i_q;
          end else begin
            hi_d = mid_q; hi_lcp_d = i_q;
          end
          state_d = StLoop;
        end
      end
      StHiWt: begin
        state_d = StHiRd;
      end
      StFinalWt: begin
        res_d = rk_val; state_d = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle && q_valid_i && q_cmd_i.op == OpQuery) begin
      lo_d = '1; hi_d = '1; mid_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    lo_lcp_q <= lo_lcp_d; hi_lcp_q <= hi_lcp_d; i_q <= i_d;
    pos_q <= pos_d; qry_q <= qry_d; len_q <= len_d; n_q <= n_d;
    is_hi_q <= is_hi_d; res_q <= res_d; short_q <= short_d;
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == StIdle)) else $error("pop outside idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  a_lcp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmpWt) |-> (i_q < 6'd33)) else $error("lcp overrun");

endmodule

>>> rtl/suffix_array_lcp_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_array_lcp_search
// suffix array binary search over a 2-bit dna reference
// ----------------------------------------------------------------------------
// Loads write one memory entry. A query checks rank 0 and rank
// ref_length-query_length, then binary-searches the ranks; each probe costs
// one rank-memory read plus one base-memory read per compared base, as each
// memory has a single read port. Up to two commands queue while the search
// runs. Each result is shown for one cycle on done_o and must be taken
// then.
module suffix_array_lcp_search
  import salcp_pkg::*;
#(
  parameter int unsigned REF_DEPTH     = RefDepthDflt,
  parameter int unsigned MAX_QUERY_LEN = MaxQueryLenDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op_i,
  input  logic [AddrW-1:0]    addr_i,
  input  logic [1:0]          base_i,
  input  logic [PosW-1:0]     ref_pos_i,
  input  logic [QueryW-1:0]   query_i,
  output logic                done_o,
  output logic [PosW-1:0]     found_pos_o,
  output logic                too_short_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t cmd, q_cmd;
  logic q_valid, q_pop, idle;
  logic [RefLenW-1:0] ref_length_q;
  logic [QLenW-1:0]   query_length_q;

  assign cmd.op      = op_e'(op_i);
  assign cmd.addr    = addr_i;
  assign cmd.base    = base_i;
  assign cmd.ref_pos = ref_pos_i;
  assign cmd.query   = query_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_length_q   <= RefLenW'(1048576);
      query_length_q <= QLenW'(21);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRefLength:   ref_length_q   <= cfg_data_i;
        CfgQueryLength: query_length_q <= cfg_data_i[QLenW-1:0];
        default: ;
      endcase
    end
  end

  salcp_front u_front (
    .clk_i, .rst_ni,
    .start_i   (start),
    .busy_o    (busy),
    .cmd_i     (cmd),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  salcp_engine #(
    .REF_DEPTH(REF_DEPTH), .MAX_QUERY_LEN(MAX_QUERY_LEN)
  ) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .ref_length_i   (ref_length_q),
    .query_length_i (query_length_q),
    .done_o,
    .idle_o         (idle),
    .found_pos_o,
    .too_short_o
  );

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !idle) else $error("result while idle");
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && too_short_o) |->
      ({1'b0, ref_length_q} < ({16'd0, query_length_q} + 22'd2)))
    else $error("too_short with long reference");
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !q_pop) |=> busy) else $error("busy dropped without pop");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the suffix array search engine
// ----------------------------------------------------------------------------
// Fills small references and their suffix arrays (sorted, and sometimes
// scrambled), then sends substring, mutated and random queries.
// Each query result is predicted from a private copy of both stores and
// checked in order. Directed tests cover too-short references, zero and
// oversized query lengths, empty search intervals, far addresses and the
// unused opcode.
// ----------------------------------------------------------------------------
module tb;
  import salcp_pkg::*;

  typedef struct {
    bit [PosW-1:0] pos;
    bit            short_ref;
  } hit_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          op_i = OpNone;
  logic [AddrW-1:0]    addr_i = '0;
  logic [1:0]          base_i = '0;
  logic [PosW-1:0]     ref_pos_i = '0;
  logic [QueryW-1:0]   query_i = '0;
  logic                done_o;
  logic [PosW-1:0]     found_pos_o;
  logic                too_short_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgRefLength;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bit [1:0]      base_mem[int unsigned];
  bit [PosW-1:0] rank_mem[int unsigned];
  longint unsigned ref_len_q = 1048576;
  longint unsigned qry_len_q = 21;
  hit_t hit_q[$];
  int unsigned fail_cnt = 0;
  int unsigned item_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_cnt = 0;

  suffix_array_lcp_search u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [1:0] base_at(longint unsigned a);
    if (a < RefDepthDflt && base_mem.exists(a)) return base_mem[a];
    return 2'd0;
  endfunction

  function automatic bit [PosW-1:0] rank_at(longint unsigned r);
    if (r < RefDepthDflt && rank_mem.exists(r)) return rank_mem[r];
    return '0;
  endfunction

  function automatic bit [1:0] qbase(bit [QueryW-1:0] q, longint unsigned i);
    return q[2*(i%32) +: 2];
  endfunction

  function automatic longint unsigned lcp_from(longint unsigned pos, bit [QueryW-1:0] q,
                                               longint unsigned from, longint unsigned len);
    longint unsigned i;
    i = from;
    while (i < len && pos + i < ref_len_q) begin
      if (qbase(q, i) != base_at(pos + i)) return i;
      i++;
    end
    return i;
  endfunction

  function automatic hit_t search(bit [QueryW-1:0] q);
    hit_t h;
    longint unsigned n, len, lo, hi, lo_lcp, hi_lcp, mid, m_pos, m_lcp, hi_pos;
    n = ref_len_q;
    len = (qry_len_q > MaxQueryLenDflt) ? MaxQueryLenDflt : qry_len_q;
    h.short_ref = 1'b0;
    h.pos = rank_at(0);
    if (n < len + 2) begin
      h.short_ref = 1'b1;
      return h;
    end
    lo_lcp = lcp_from(rank_at(0), q, 0, len);
    if (lo_lcp == len) return h;
    hi_pos = rank_at(n - len);
    hi_lcp = lcp_from(hi_pos, q, 0, len);
    if (hi_lcp == len) begin
      h.pos = hi_pos;
      return h;
    end
    lo = 0;
    hi = n - len;
    forever begin
      if (hi <= lo + 2) begin
        h.pos = rank_at(lo + 1);
        return h;
      end
      mid = (lo + hi) >> 1;
      m_pos = rank_at(mid);
      m_lcp = lcp_from(m_pos, q, (lo_lcp < hi_lcp) ? lo_lcp : hi_lcp, len);
      if (m_lcp == len) begin
        h.pos = m_pos;
        return h;
      end
      if (m_pos + m_lcp >= n || qbase(q, m_lcp) > base_at(m_pos + m_lcp)) begin
        lo = mid;
        lo_lcp = m_lcp;
      end else begin
        hi = mid;
        hi_lcp = m_lcp;
      end
    end
  endfunction

  task automatic send_cmd(op_e op, bit [AddrW-1:0] addr, bit [1:0] base,
                          bit [PosW-1:0] pos, bit [QueryW-1:0] q);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    addr_i <= addr;
    base_i <= base;
    ref_pos_i <= pos;
    query_i <= q;
    do @(posedge clk_i); while (busy);
    item_cnt++;
    case (op)
      OpLoadBase: base_mem[addr] = base;
      OpLoadRank: rank_mem[addr] = pos;
      OpQuery:    hit_q.push_back(search(q));
      default: ;
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [CfgIdxW-1:0] idx, bit [CfgDataW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgRefLength) ref_len_q = 64'(val);
    else qry_len_q = 64'(val[QLenW-1:0]);
  endtask

  function automatic bit suffix_less(int unsigned a, int unsigned b, int unsigned n);
    int unsigned k;
    k = 0;
    while (a + k < n && b + k < n) begin
      if (base_mem[a+k] != base_mem[b+k]) return base_mem[a+k] < base_mem[b+k];
      k++;
    end
    return a > b;
  endfunction

  // load a reference of n bases with its suffix array, then query it
  task automatic run_case(int unsigned n, int unsigned len, int unsigned nq, bit scramble);
    int unsigned sa[$];
    int unsigned s, j, p;
    bit [QueryW-1:0] q;
    write_reg(CfgRefLength, CfgDataW'(n));
    write_reg(CfgQueryLength, CfgDataW'(len));
    for (p = 0; p < n; p++)
      send_cmd(OpLoadBase, AddrW'(p), 2'($urandom_range(3)), '0, '0);
    for (p = 0; p < n; p++) begin
      j = 0;
      while (j < sa.size() && suffix_less(sa[j], p, n)) j++;
      sa.insert(j, p);
    end
    for (p = 0; p < n; p++)
      send_cmd(OpLoadRank, AddrW'(p), '0,
               scramble ? PosW'($urandom_range(20'hFFFFF)) : PosW'(sa[p]), '0);
    for (j = 0; j < nq; j++) begin
      q = {$urandom, $urandom};
      s = $urandom_range(n - 1);
      if ($urandom_range(99) < 80) begin
        for (p = 0; p < 32; p++)
          if (s + p < n) q[2*p +: 2] = base_mem[s+p];
        if ($urandom_range(3) == 0) q[2*$urandom_range(31) +: 2] = 2'($urandom_range(3));
      end
      send_cmd($urandom_range(19) == 0 ? OpNone : OpQuery, AddrW'($urandom),
               2'($urandom), PosW'($urandom), q);
    end
  endtask

  task automatic test_short_reference;
    write_reg(CfgRefLength, CfgDataW'(1));
    write_reg(CfgQueryLength, CfgDataW'(1));
    send_cmd(OpLoadRank, '0, '0, 20'hFFFFF, '0);
    send_cmd(OpLoadBase, 20'hFFFFF, 2'd3, '0, '0);
    send_cmd(OpLoadRank, 20'hFFFFF, '0, 20'hFFFFF, '0);
    send_cmd(OpNone, 20'hFFFFF, 2'd3, 20'hFFFFF, '1);
    send_cmd(OpQuery, '0, '0, '0, '1);
    send_cmd(OpQuery, '0, '0, '0, '0);
    write_reg(CfgQueryLength, CfgDataW'(0));
    send_cmd(OpQuery, '0, '0, '0, '1);
  endtask

  task automatic test_zero_length;
    write_reg(CfgRefLength, CfgDataW'(4));
    send_cmd(OpQuery, '0, '0, '0, 64'h5555_aaaa_5555_aaaa);
  endtask

  task automatic test_length_edges;
    run_case(5, 3, 3, 1'b0);
    run_case(34, 63, 6, 1'b0);
    run_case(12, 3, 6, 1'b1);
    start <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    write_reg(CfgRefLength, CfgDataW'(1048576));
    write_reg(CfgQueryLength, CfgDataW'(32));
  endtask

  task automatic test_random;
    int unsigned n, len;
    while (item_cnt < 1750) begin
      case (item_cnt * 3 / 1750)
        0: idle_pct = 17;
        1: idle_pct = 54;
        default: idle_pct = 0;
      endcase
      len = ($urandom_range(9) == 0) ? $urandom_range(33, 63) : $urandom_range(1, 32);
      if ($urandom_range(9) == 0) n = $urandom_range(1, 40);
      else n = $urandom_range(((len > 32) ? 32 : len) + 2, 64);
      run_case(n, len, $urandom_range(15, 40), $urandom_range(9) == 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (hit_q.size() == 0) begin
        $error("result with no query pending: found_pos %0h", found_pos_o);
        fail_cnt++;
      end else begin
        if (found_pos_o !== hit_q[0].pos) begin
          $error("found_pos expected %0h actual %0h", hit_q[0].pos, found_pos_o);
          fail_cnt++;
        end
        if (too_short_o !== hit_q[0].short_ref) begin
          $error("too_short expected %0b actual %0b", hit_q[0].short_ref, too_short_o);
          fail_cnt++;
        end
        void'(hit_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_reference();
    test_zero_length();
    test_length_edges();
    test_random();
    drain();
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
